// ===== sv/lts_pkg.sv =====
`timescale 1ns / 1ps

package lts_pkg;

	// Character codes with a meaning of their own.
	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CASE_OFFSET   = 8'h20;

	// Counter limits of the output fields.
	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
	localparam logic [19:0] COL_MAX  = 20'hFFFFF;

	// Configuration register indexes.
	typedef logic [2:0] cfg_idx_t;
	localparam cfg_idx_t REG_TERM_LENGTH = 3'd0;
	localparam cfg_idx_t REG_TERM_LOW    = 3'd1;
	localparam cfg_idx_t REG_TERM_SECOND = 3'd2;
	localparam cfg_idx_t REG_TERM_THIRD  = 3'd3;
	localparam cfg_idx_t REG_TERM_HIGH   = 3'd4;
	localparam cfg_idx_t REG_MATCH_MODE  = 3'd5;

	// Search options as seen by the datapath.
	typedef struct packed {
		logic [5:0] len;
		logic       case_sens;
		logic       whole;
	} mode_t;

	// Control that every cell of the window row receives.
	typedef struct packed {
		logic shift;
		logic clear;
		logic case_sens;
	} cell_ctrl_t;

	function automatic logic [7:0] fold(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return (c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]}) ||
			(c == CH_UNDERSCORE);
	endfunction

endpackage

// ===== sv/lts_ifs.sv =====
`timescale 1ns / 1ps

interface lts_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source(output valid, text_byte, end_of_text, input ready);
	modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface lts_hit_if;
	logic        valid;
	logic        ready;
	logic [23:0] line_number;
	logic [19:0] start_column;
	logic [5:0]  match_length;

	modport source(output valid, line_number, start_column, match_length, input ready);
	modport sink(input valid, line_number, start_column, match_length, output ready);
endinterface

// ===== sv/lts_cell.sv =====
`timescale 1ns / 1ps

module lts_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lts_pkg::cell_ctrl_t    ctrl,
	input  logic [7:0]             d_in,
	input  logic                   v_in,
	input  logic [7:0]             tchar,
	output logic [7:0]             d_q,
	output logic                   v_q,
	output logic                   eq,
	output logic                   word
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (ctrl.clear) begin
			v_q <= 1'b0;
		end else if (ctrl.shift) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			d_q <= d_in;
		end
	end

	// The compare looks at the byte this cell takes on the current shift,
	// so the hit is known in the cycle the item is accepted.
	always_comb begin
		if (ctrl.case_sens) begin
			eq = v_in && (d_in == tchar);
		end else begin
			eq = v_in && (lts_pkg::fold(d_in) == lts_pkg::fold(tchar));
		end
	end

	assign word = v_q && lts_pkg::is_word(d_q);

endmodule

// ===== sv/lts_cfg.sv =====
`timescale 1ns / 1ps

module lts_cfg #(
	parameter int MAX_TERM = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  lts_pkg::cfg_idx_t         cfg_index,
	input  logic [63:0]               cfg_data,
	output lts_pkg::mode_t            mode,
	output logic [MAX_TERM-1:0][7:0]  aligned,
	output logic [MAX_TERM-1:0]       mask
);

	localparam int IDX_W = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;

	logic [5:0]                term_length_q;
	logic [1:0]                match_mode_q;
	logic [MAX_TERM-1:0][7:0]  term_q;
	logic [5:0]                len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_length_q <= 6'd1;
			match_mode_q  <= 2'd0;
		end else if (cfg_write) begin
			if (cfg_index == lts_pkg::REG_TERM_LENGTH) begin
				term_length_q <= cfg_data[5:0];
			end
			if (cfg_index == lts_pkg::REG_MATCH_MODE) begin
				match_mode_q <= cfg_data[1:0];
			end
		end
	end

	for (genvar p = 0; p < MAX_TERM; p++) begin : g_term
		localparam int WORD = p / 8;
		localparam int LANE = p % 8;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				term_q[p] <= 8'h00;
			end else if (cfg_write &&
				cfg_index == lts_pkg::cfg_idx_t'(lts_pkg::REG_TERM_LOW + WORD)) begin
				term_q[p] <= cfg_data[8*LANE +: 8];
			end
		end
	end

	assign len = (term_length_q > 6'(MAX_TERM)) ? 6'(MAX_TERM) : term_length_q;

	assign mode.len       = len;
	assign mode.case_sens = match_mode_q[0];
	assign mode.whole     = match_mode_q[1];

	// Cell i holds the byte that arrived i items ago, so it must see the
	// term character counted back from the end of the term.
	always_comb begin
		logic [5:0] idx;
		idx = 6'd0;
		for (int i = 0; i < MAX_TERM; i++) begin
			idx        = len - 6'(i) - 6'd1;
			aligned[i] = term_q[idx[IDX_W-1:0]];
			mask[i]    = 6'(i) < len;
		end
	end

endmodule

// ===== sv/literal_text_search.sv =====
`timescale 1ns / 1ps

// Channel  Modport  Payload                                     Meaning
// text     sink     text_byte[7:0], end_of_text                 one text character or end mark
// hit      source   line_number[23:0], start_column[19:0],      one reported occurrence
//                   match_length[5:0]
// cfg      write    cfg_write, cfg_index[2:0], cfg_data[63:0]   register writes, no read-back
//
// One item per cycle unless stalled. A row of MAX_TERM cells shifts the text and compares
// every window position against the term in the cycle the item is accepted.
// A result is registered and appears on hit in the cycle after the item that resolves it.
// Reset puts the registers at their defaults, empties the window and sets line 1.
// text.ready drops only while a result sits in the output register and hit.ready is low.

module literal_text_search #(
	parameter int MAX_TERM = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  lts_pkg::cfg_idx_t  cfg_index,
	input  logic [63:0]        cfg_data,
	lts_text_if.sink           text,
	lts_hit_if.source          hit
);

	localparam int IDX_W = (MAX_TERM > 1) ? $clog2(MAX_TERM) : 1;

	lts_pkg::mode_t             mode;
	logic [MAX_TERM-1:0][7:0]   aligned;
	logic [MAX_TERM-1:0]        mask;
	lts_pkg::cell_ctrl_t        ctrl;
	logic [MAX_TERM-1:0][7:0]   win_byte;
	logic [MAX_TERM-1:0]        win_valid;
	logic [MAX_TERM-1:0]        eq;
	logic [MAX_TERM-1:0]        word;

	logic [23:0] line_q;
	logic [19:0] col_q;
	logic [19:0] nas_q;
	logic        pend_q;
	logic [19:0] pcol_q;
	logic        held_cr_q;

	logic        out_valid_q;
	logic [23:0] out_line_q;
	logic [19:0] out_col_q;
	logic [5:0]  out_len_q;

	logic        acc;
	logic [7:0]  b;
	logic        is_lf;
	logic        is_cr;
	logic        normal;
	logic        pend_emit;
	logic [20:0] pend_sum;
	logic [19:0] nas_eff;
	logic [19:0] start;
	logic [20:0] start_sum;
	logic [5:0]  lm1;
	logic        all_eq;
	logic        hit_now;
	logic        hit_defer;
	logic        hit_imm;
	logic        emit;
	logic [19:0] emit_col;

	lts_cfg #(.MAX_TERM(MAX_TERM)) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.mode     (mode),
		.aligned  (aligned),
		.mask     (mask)
	);

	assign acc    = text.valid && text.ready;
	assign b      = text.text_byte;
	assign is_lf  = (b == lts_pkg::CH_LF);
	assign is_cr  = (b == lts_pkg::CH_CR);
	assign normal = !text.end_of_text && !is_lf;

	assign ctrl.shift     = acc && normal;
	assign ctrl.clear     = acc && !normal;
	assign ctrl.case_sens = mode.case_sens;

	for (genvar i = 0; i < MAX_TERM; i++) begin : g_cell
		lts_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctrl  (ctrl),
			.d_in  ((i == 0) ? b : win_byte[(i == 0) ? 0 : i-1]),
			.v_in  ((i == 0) ? 1'b1 : win_valid[(i == 0) ? 0 : i-1]),
			.tchar (aligned[i]),
			.d_q   (win_byte[i]),
			.v_q   (win_valid[i]),
			.eq    (eq[i]),
			.word  (word[i])
		);
	end

	// A held hit is confirmed by any following byte, except a word
	// character when whole words are asked for, or an LF straight after a CR.
	assign pend_emit = pend_q && (!mode.whole || !lts_pkg::is_word(b));
	assign pend_sum  = {1'b0, pcol_q} + 21'(mode.len);
	assign nas_eff   = !pend_emit ? nas_q :
		(pend_sum > {1'b0, lts_pkg::COL_MAX}) ? lts_pkg::COL_MAX : pend_sum[19:0];

	assign start     = col_q - 20'(mode.len) + 20'd1;
	assign start_sum = {1'b0, start} + 21'(mode.len);
	assign lm1       = mode.len - 6'd1;
	assign all_eq    = &(eq | ~mask);

	// The character before the occurrence sits in cell len-1 before the shift.
	assign hit_now = (mode.len != 6'd0) && all_eq && (start >= nas_eff) &&
		!(mode.whole && word[lm1[IDX_W-1:0]]);
	assign hit_defer = hit_now && (is_cr || mode.whole);
	assign hit_imm   = hit_now && !is_cr && !mode.whole && !pend_emit;

	always_comb begin
		emit     = 1'b0;
		emit_col = pcol_q;
		if (text.end_of_text) begin
			emit = pend_q;
		end else if (is_lf) begin
			emit = pend_q && !held_cr_q;
		end else if (pend_emit) begin
			emit = 1'b1;
		end else if (hit_imm) begin
			emit     = 1'b1;
			emit_col = start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q    <= 24'd1;
			col_q     <= 20'd0;
			nas_q     <= 20'd0;
			pend_q    <= 1'b0;
			pcol_q    <= 20'd0;
			held_cr_q <= 1'b0;
		end else if (acc) begin
			if (normal) begin
				col_q     <= (col_q == lts_pkg::COL_MAX) ? col_q : col_q + 20'd1;
				held_cr_q <= is_cr;
				pend_q    <= hit_defer;
				if (hit_defer) begin
					pcol_q <= start;
				end
				if (hit_imm) begin
					nas_q <= (start_sum > {1'b0, lts_pkg::COL_MAX}) ?
						lts_pkg::COL_MAX : start_sum[19:0];
				end else begin
					nas_q <= nas_eff;
				end
			end else begin
				col_q     <= 20'd0;
				nas_q     <= 20'd0;
				pend_q    <= 1'b0;
				pcol_q    <= 20'd0;
				held_cr_q <= 1'b0;
				if (text.end_of_text) begin
					line_q <= 24'd1;
				end else if (line_q != lts_pkg::LINE_MAX) begin
					line_q <= line_q + 24'd1;
				end
			end
		end
	end

	// Output register: a new item is taken while it is empty or whenever the held result leaves.
	assign text.ready = !out_valid_q || hit.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc && emit) begin
			out_valid_q <= 1'b1;
		end else if (hit.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && emit) begin
			out_line_q <= line_q;
			out_col_q  <= emit_col;
			out_len_q  <= mode.len;
		end
	end

	assign hit.valid        = out_valid_q;
	assign hit.line_number  = out_line_q;
	assign hit.start_column = out_col_q;
	assign hit.match_length = out_len_q;

endmodule

// ===== sv/lts_checker.sv =====
`timescale 1ns / 1ps

module lts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        text_valid,
	input logic        text_ready,
	input logic        hit_valid,
	input logic        hit_ready,
	input logic [23:0] line_number,
	input logic [19:0] start_column,
	input logic [5:0]  match_length
);

	a_hit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=> hit_valid)
		else $error("hit item dropped while stalled");

	a_hit_stable: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && !hit_ready |=>
		$stable(line_number) && $stable(start_column) && $stable(match_length))
		else $error("hit payload changed while stalled");

	a_text_open: assert property (@(posedge clk) disable iff (!arst_n)
		!hit_valid |-> text_ready)
		else $error("text input blocked with an empty output");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid |-> (match_length != 6'd0) && (line_number != 24'd0))
		else $error("hit with zero length or zero line");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		hit_valid && hit_ready && !text_valid |=> !hit_valid)
		else $error("hit item without an accepted text item");

endmodule

bind literal_text_search lts_checker u_lts_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.text_valid  (text.valid),
	.text_ready  (text.ready),
	.hit_valid   (hit.valid),
	.hit_ready   (hit.ready),
	.line_number (hit.line_number),
	.start_column(hit.start_column),
	.match_length(hit.match_length)
);

// ===== test/lts_tb_pkg.sv =====
`timescale 1ns / 1ps

package lts_tb_pkg;
	import lts_pkg::*;

	localparam int TERM_SLOTS    = 32;
	localparam int HISTORY_DEPTH = TERM_SLOTS + 1;

	localparam logic [1:0] MODE_FOLD_CASE  = 2'b00;
	localparam logic [1:0] MODE_CASE_SENS  = 2'b01;
	localparam logic [1:0] MODE_WHOLE_WORD = 2'b10;

	typedef struct packed {
		logic [23:0] line_number;
		logic [19:0] start_column;
		logic [5:0]  match_length;
	} occurrence_t;

	class hit_scoreboard;
		occurrence_t expected_hits[$];
		int          error_count;
		logic [5:0]  term_len;
		logic [63:0] term_words[4];
		logic [1:0]  mode;
		logic [7:0]  history[HISTORY_DEPTH];
		int unsigned history_fill;
		logic [23:0] line_count;
		int unsigned column_count;
		int unsigned resume_column;
		bit          hit_pending;
		int unsigned pending_start;
		bit          last_was_cr;

		function new();
			error_count = 0;
			term_len = 6'd1;
			foreach (term_words[i]) term_words[i] = '0;
			mode = MODE_FOLD_CASE;
			line_count = 24'd1;
			restart_line();
		endfunction

		function void restart_line();
			foreach (history[i]) history[i] = 8'h00;
			history_fill = 0;
			column_count = 0;
			resume_column = 0;
			hit_pending = 0;
			pending_start = 0;
			last_was_cr = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [63:0] data);
			case (idx)
			REG_TERM_LENGTH: term_len = data[5:0];
			REG_TERM_LOW:    term_words[0] = data;
			REG_TERM_SECOND: term_words[1] = data;
			REG_TERM_THIRD:  term_words[2] = data;
			REG_TERM_HIGH:   term_words[3] = data;
			REG_MATCH_MODE:  mode = data[1:0];
			default: ;
			endcase
		endfunction

		function int unsigned active_len();
			return (term_len > TERM_SLOTS) ? TERM_SLOTS : term_len;
		endfunction

		function int unsigned clip_column(int unsigned v);
			return (v > COL_MAX) ? COL_MAX : v;
		endfunction

		static function logic [7:0] lower_case(logic [7:0] c);
			if (c >= "A" && c <= "Z") begin
				return c + 8'h20;
			end
			return c;
		endfunction

		static function bit word_char(logic [7:0] c);
			return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
				(c >= "0" && c <= "9") || (c == CH_UNDERSCORE);
		endfunction

		function logic [7:0] term_char(int unsigned k);
			return term_words[k / 8][(k % 8) * 8 +: 8];
		endfunction

		function void record(int unsigned col);
			occurrence_t o;
			o.line_number = line_count;
			o.start_column = 20'(col);
			o.match_length = 6'(active_len());
			expected_hits.push_back(o);
		endfunction

		// Works out the occurrence, if any, that one accepted text item reports.
		function void note_text(logic [7:0] ch, logic eot);
			bit          sens;
			bit          whole_only;
			bit          found;
			bit          emitted;
			int unsigned len;
			int unsigned cur;
			int unsigned start;
			logic [7:0]  c;
			logic [7:0]  t;
			sens = (mode & MODE_CASE_SENS) != 0;
			whole_only = (mode & MODE_WHOLE_WORD) != 0;
			len = active_len();
			emitted = 0;
			if (eot) begin
				if (hit_pending) begin
					record(pending_start);
				end
				restart_line();
				line_count = 24'd1;
				return;
			end
			if (ch == CH_LF) begin
				// A hit on a term ending in CR is void when the CR belongs to a CR LF pair.
				if (hit_pending && !last_was_cr) begin
					record(pending_start);
				end
				if (line_count != LINE_MAX) begin
					line_count++;
				end
				restart_line();
				return;
			end
			if (hit_pending) begin
				if (!whole_only || !word_char(ch)) begin
					record(pending_start);
					emitted = 1;
					resume_column = clip_column(pending_start + len);
				end
				hit_pending = 0;
			end
			cur = column_count;
			column_count = clip_column(cur + 1);
			for (int i = HISTORY_DEPTH - 1; i > 0; i--) begin
				history[i] = history[i - 1];
			end
			history[0] = ch;
			if (history_fill < HISTORY_DEPTH) begin
				history_fill++;
			end
			found = 0;
			start = 0;
			if (len >= 1 && history_fill >= len) begin
				start = cur - (len - 1);
				found = start >= resume_column;
				for (int k = 0; k < len; k++) begin
					c = history[len - 1 - k];
					t = term_char(k);
					if (sens ? (c != t) : (lower_case(c) != lower_case(t))) begin
						found = 0;
					end
				end
				if (found && whole_only && history_fill > len && word_char(history[len])) begin
					found = 0;
				end
			end
			if (found) begin
				if (ch == CH_CR || whole_only) begin
					hit_pending = 1;
					pending_start = start;
				end else if (!emitted) begin
					record(start);
					resume_column = clip_column(start + len);
				end
			end
			last_was_cr = (ch == CH_CR);
		endfunction

		function void check_hit(occurrence_t got);
			occurrence_t want;
			if (expected_hits.size() == 0) begin
				$error("hit with none expected: line_number %0d start_column %0d match_length %0d",
					got.line_number, got.start_column, got.match_length);
				error_count++;
				return;
			end
			want = expected_hits.pop_front();
			if (got.line_number != want.line_number) begin
				$error("line_number: expected %0d, actual %0d", want.line_number, got.line_number);
				error_count++;
			end
			if (got.start_column != want.start_column) begin
				$error("start_column: expected %0d, actual %0d", want.start_column,
					got.start_column);
				error_count++;
			end
			if (got.match_length != want.match_length) begin
				$error("match_length: expected %0d, actual %0d", want.match_length,
					got.match_length);
				error_count++;
			end
		endfunction
	endclass

endpackage

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import lts_pkg::*;
	import lts_tb_pkg::*;

	localparam int STALL_LIMIT   = 5000;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 20;
	localparam int PHASE_ITEMS   = 100;
	localparam int RANDOM_PHASES = 9;

	typedef struct packed {
		logic       eot;
		logic [7:0] ch;
	} text_item_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	cfg_idx_t    cfg_index;
	logic [63:0] cfg_data;

	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	bit            hold_request = 0;
	bit            hold_taken = 0;
	int            quiet_cycles = 0;
	text_item_t    text_plan[$];
	hit_scoreboard hits = new();

	lts_text_if text_ch();
	lts_hit_if  hit_ch();

	literal_text_search #(.MAX_TERM(TERM_SLOTS)) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.text(text_ch),
		.hit(hit_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && hit_ch.valid && hit_ch.ready) begin
			hits.check_hit(occurrence_t'{hit_ch.line_number, hit_ch.start_column,
				hit_ch.match_length});
		end
	end

	always @(posedge clk) begin
		if ((text_ch.valid && text_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL literal_text_search");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: random stalls, plus one long hold-off so the block backs up.
	initial begin
		hit_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1;
				hit_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			hit_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_text(logic [7:0] ch, logic eot);
		while ($urandom_range(99) < send_idle_pct) begin
			text_ch.valid <= 1'b0;
			@(negedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.text_byte <= ch;
		text_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_ch.ready);
		hits.note_text(ch, eot);
		@(negedge clk);
	endtask

	task automatic send_plan();
		foreach (text_plan[i]) send_text(text_plan[i].ch, text_plan[i].eot);
		text_plan.delete();
	endtask

	// Nothing is left pending in the block once the last expected item has come.
	task automatic wait_idle();
		text_ch.valid <= 1'b0;
		while (hits.expected_hits.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [63:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		hits.write_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic configure(int unsigned len, logic [255:0] term, logic [1:0] mode_bits);
		write_reg(REG_TERM_LENGTH, 64'(len));
		write_reg(REG_TERM_LOW, term[63:0]);
		write_reg(REG_TERM_SECOND, term[127:64]);
		write_reg(REG_TERM_THIRD, term[191:128]);
		write_reg(REG_TERM_HIGH, term[255:192]);
		write_reg(REG_MATCH_MODE, 64'(mode_bits));
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [255:0] pack_term(string s);
		logic [255:0] v;
		v = '0;
		for (int i = 0; i < s.len(); i++) begin
			v[i * 8 +: 8] = s[i];
		end
		return v;
	endfunction

	function automatic void add_string(string s);
		for (int i = 0; i < s.len(); i++) begin
			text_plan.push_back(text_item_t'{1'b0, s[i]});
		end
	endfunction

	function automatic void add_byte(logic [7:0] ch, logic eot);
		text_plan.push_back(text_item_t'{eot, ch});
	endfunction

	// Characters that make hits and near misses likely.
	function automatic logic [7:0] term_alphabet();
		case ($urandom_range(9))
		0: return "a";
		1: return "A";
		2: return "b";
		3: return "B";
		4: return CH_UNDERSCORE;
		5: return "1";
		6: return " ";
		7: return CH_CR;
		8: return 8'hE9;
		default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic random_phase(int phase);
		logic [255:0] term;
		logic [1:0]   mode_bits;
		logic [7:0]   c;
		int unsigned  len;
		int unsigned  eff;
		int unsigned  r;
		case (phase % 4)
		0: begin
			send_idle_pct = 0;
			recv_stall_pct = 0;
		end
		1: begin
			send_idle_pct = 82;
			recv_stall_pct = 0;
		end
		2: begin
			send_idle_pct = 0;
			recv_stall_pct = 82;
		end
		default: begin
			send_idle_pct = 14;
			recv_stall_pct = 14;
		end
		endcase
		r = $urandom_range(19);
		if (phase == 0) begin
			len = TERM_SLOTS;
		end else if (phase == 1) begin
			len = 63;
		end else if (r == 0) begin
			len = 0;
		end else if (r == 1) begin
			len = $urandom_range(63, TERM_SLOTS + 1);
		end else if (r < 5) begin
			len = $urandom_range(TERM_SLOTS, 5);
		end else begin
			len = $urandom_range(4, 1);
		end
		eff = (len > TERM_SLOTS) ? TERM_SLOTS : len;
		term = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		for (int k = 0; k < eff; k++) begin
			term[k * 8 +: 8] = term_alphabet();
		end
		mode_bits = 2'($urandom_range(3));
		configure(len, term, mode_bits);
		while (text_plan.size() < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 35 && eff > 0) begin
				// Copies of the term, some with letters of the other case.
				for (int k = 0; k < eff; k++) begin
					c = term[k * 8 +: 8];
					if (((c >= "a" && c <= "z") || (c >= "A" && c <= "Z")) &&
							$urandom_range(3) == 0) begin
						c = c ^ 8'h20;
					end
					add_byte(c, 1'b0);
				end
			end else if (r < 60) begin
				add_byte(term_alphabet(), 1'b0);
			end else if (r < 70) begin
				add_byte($urandom_range(1) ? " " : ".", 1'b0);
			end else if (r < 76) begin
				add_byte(CH_LF, 1'b0);
			end else if (r < 80) begin
				add_byte(CH_CR, 1'b0);
				add_byte(CH_LF, 1'b0);
			end else if (r < 82) begin
				add_byte(8'($urandom_range(255)), 1'b1);
			end else begin
				add_byte(8'($urandom_range(255)), 1'b0);
			end
		end
		add_byte(8'($urandom_range(255)), 1'b1);
		send_plan();
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_TERM_LENGTH;
		cfg_data = '0;
		text_ch.valid = 1'b0;
		text_ch.text_byte = 8'h00;
		text_ch.end_of_text = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Case folding and the byte extremes.
		configure(1, pack_term("a"), MODE_FOLD_CASE);
		add_string("A");
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'hFF, 1'b1);
		send_plan();
		wait_idle();

		// Hits do not overlap: the scan resumes after the end of the last one.
		configure(2, pack_term("aa"), MODE_FOLD_CASE);
		add_string("aAaa");
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		configure(2, pack_term("Ab"), MODE_CASE_SENS);
		add_string("abAb");
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		// Whole words, with hits resolved by a separator and by the text end.
		configure(2, pack_term("ab"), MODE_WHOLE_WORD);
		add_string("ab ab_");
		add_byte(CH_LF, 1'b0);
		add_string("ab");
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		// A term ending in CR is void when the CR is dropped before LF.
		configure(2, {240'h0, CH_CR, "x"}, MODE_CASE_SENS | MODE_WHOLE_WORD);
		add_string("x");
		add_byte(CH_CR, 1'b0);
		add_byte(CH_LF, 1'b0);
		add_string("x");
		add_byte(CH_CR, 1'b0);
		add_string("z");
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		configure(0, pack_term("a"), MODE_FOLD_CASE);
		add_string("a");
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		// Bytes above ASCII are never folded.
		configure(1, 256'h0C1, MODE_FOLD_CASE);
		add_byte(8'hE1, 1'b0);
		add_byte(8'hC1, 1'b0);
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		// Every item hits while the result side holds off, so the input stalls.
		configure(1, pack_term("a"), MODE_FOLD_CASE);
		hold_request = 1;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			add_string("a");
		end
		add_byte(8'h00, 1'b1);
		send_plan();
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_phase(p);
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (hits.error_count == 0 && hits.expected_hits.size() == 0) begin
			$display("PASS literal_text_search");
		end else begin
			$display("FAIL literal_text_search");
		end
		$finish;
	end

endmodule
